// ----- src/ootre_pkg.sv -----
// Shared types and constants for the tristate on-off-keying remote encoder.
package ootre_pkg;

   // Request command codes.
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_LOAD12     = 3'd1;
   localparam logic [2:0] CMD_LOAD_HOUSE = 3'd2;
   localparam logic [2:0] CMD_LOAD_444   = 3'd3;
   localparam logic [2:0] CMD_RAW        = 3'd4;
   localparam logic [2:0] CMD_BELL       = 3'd5;

   // Control register indexes.
   localparam logic [2:0] CSR_PT_SHORT  = 3'd0;
   localparam logic [2:0] CSR_PT_LONG   = 3'd1;
   localparam logic [2:0] CSR_HX_SHORT  = 3'd2;
   localparam logic [2:0] CSR_HX_LONG   = 3'd3;
   localparam logic [2:0] CSR_PT_REPEAT = 3'd4;
   localparam logic [2:0] CSR_HX_REPEAT = 3'd5;

   localparam logic [7:0] REPEAT_RESET = 8'd4;

   // Frame positions.
   localparam logic [6:0] PT_DATA_END  = 7'd48;
   localparam logic [6:0] PT_SYNC_LOW  = 7'd49;
   localparam logic [6:0] PT_FRAME_END = 7'd80;
   localparam logic [6:0] HX_DATA_END  = 7'd26;
   localparam logic [6:0] HX_FRAME_END = 7'd32;
   localparam logic [6:0] HX_DATA_BASE = 7'd2;

   localparam logic [7:0] MASK_FIRST   = 8'h80;
   localparam int         PATTERN_BITS = 24;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  house_code;
      logic [11:0] code_word;
      logic [3:0]  state_bits;
      logic [23:0] raw_pattern;
   } req_type;

   typedef struct packed {
      logic       tx_level;
      logic       preload_written;
      logic [7:0] preload_value;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0] pt_short_preload;
      logic [7:0] pt_long_preload;
      logic [7:0] hx_short_preload;
      logic [7:0] hx_long_preload;
      logic [7:0] pt_repeat_count;
      logic [7:0] hx_repeat_count;
   } cfg_type;

   typedef struct packed {
      logic       busy;
      logic [6:0] position;
   } status_type;

endpackage

// ----- src/ootre_framer.sv -----
// Pulse pattern store and frame sequencer: each accepted request updates the state registers.
module ootre_framer (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ootre_pkg::req_type  request,
   input  ootre_pkg::cfg_type  cfg,
   output ootre_pkg::rsp_type  result,
   output ootre_pkg::status_type status
);
   import ootre_pkg::*;

   logic [PATTERN_BITS-1:0] pattern_ff, pattern_in;
   logic [6:0]              position_ff, position_in;
   logic [7:0]              bit_mask_ff, bit_mask_in;
   logic [7:0]              repeats_left_ff, repeats_left_in;
   logic                    doorbell_mode_ff, doorbell_mode_in;
   logic                    line_level_ff, line_level_in;

   logic [7:0] mask_eff;
   logic [6:0] hx_offset;
   logic       pt_hit;
   logic       hx_hit;
   logic       tick_written;
   logic [7:0] tick_preload;

   // Tristate coding: each code bit covers two pattern bits, a set bit gives 00
   // and a clear bit gives 01. Pattern bit k sits at flat index 23-k.
   function automatic logic [PATTERN_BITS-1:0] tristate_code(
      input logic [2:0]  cmd,
      input logic [4:0]  house,
      input logic [11:0] word,
      input logic [3:0]  data
   );
      logic [PATTERN_BITS-1:0] pat;
      logic                    set;
      pat = '0;
      for (int k = 0; k < PATTERN_BITS; k++) begin
         if (cmd == CMD_LOAD12) begin
            set = word[k/2];
         end else if (cmd == CMD_LOAD_HOUSE) begin
            if (k <= 9) set = house[k/2];
            else if (k <= 19) set = (word == 12'((k - 10) / 2));
            else set = data[(k-20)/2];
         end else begin
            if (k <= 7) set = house[k/2];
            else if (k <= 15) set = word[(k-8)/2];
            else set = data[(k-16)/2];
         end
         pat[PATTERN_BITS-1-k] = ~set & (k % 2 == 1);
      end
      return pat;
   endfunction

   function automatic logic byte_hit(
      input logic [PATTERN_BITS-1:0] pat,
      input logic [7:0]              mask,
      input logic [1:0]              sel
   );
      logic hit;
      case (sel)
         2'd0:    hit = |(pat[23:16] & mask);
         2'd1:    hit = |(pat[15:8] & mask);
         2'd2:    hit = |(pat[7:0] & mask);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   assign mask_eff  = (position_ff == '0 || bit_mask_ff == '0) ? MASK_FIRST : bit_mask_ff;
   assign hx_offset = position_ff - HX_DATA_BASE;
   assign pt_hit    = byte_hit(pattern_ff, mask_eff, position_ff[5:4]);
   assign hx_hit    = byte_hit(pattern_ff, mask_eff, hx_offset[5:4]);

   always_comb begin
      pattern_in       = pattern_ff;
      position_in      = position_ff;
      bit_mask_in      = bit_mask_ff;
      repeats_left_in  = repeats_left_ff;
      doorbell_mode_in = doorbell_mode_ff;
      line_level_in    = line_level_ff;
      tick_written     = 1'b0;
      tick_preload     = '0;

      unique case (request.command) inside
         CMD_TICK: begin
            if (repeats_left_ff != '0) begin
               tick_written = 1'b1;
               bit_mask_in  = mask_eff;
               if (doorbell_mode_ff) begin
                  if (position_ff == '0) begin
                     line_level_in = 1'b0;
                     tick_preload  = cfg.hx_long_preload;
                  end else if (position_ff == 7'd1) begin
                     line_level_in = 1'b1;
                     tick_preload  = cfg.hx_short_preload;
                  end else if (position_ff <= HX_DATA_END) begin
                     if (!position_ff[0]) begin
                        line_level_in = 1'b0;
                        tick_preload  = hx_hit ? cfg.hx_short_preload : cfg.hx_long_preload;
                     end else begin
                        line_level_in = 1'b1;
                        tick_preload  = hx_hit ? cfg.hx_long_preload : cfg.hx_short_preload;
                        bit_mask_in   = mask_eff >> 1;
                     end
                  end else begin
                     line_level_in = 1'b0;
                     tick_preload  = cfg.hx_long_preload;
                  end
                  if (position_ff >= HX_FRAME_END) begin
                     position_in     = '0;
                     repeats_left_in = repeats_left_ff - 8'd1;
                  end else begin
                     position_in = position_ff + 7'd1;
                  end
               end else begin
                  if (position_ff < PT_DATA_END) begin
                     if (!position_ff[0]) begin
                        line_level_in = 1'b1;
                        tick_preload  = pt_hit ? cfg.pt_long_preload : cfg.pt_short_preload;
                     end else begin
                        line_level_in = 1'b0;
                        tick_preload  = pt_hit ? cfg.pt_short_preload : cfg.pt_long_preload;
                        bit_mask_in   = mask_eff >> 1;
                     end
                  end else begin
                     // Sync pulse high at the first position after the data, low at
                     // the next, then the line holds through the short gaps.
                     if (position_ff == PT_DATA_END) line_level_in = 1'b1;
                     else if (position_ff == PT_SYNC_LOW) line_level_in = 1'b0;
                     tick_preload = cfg.pt_short_preload;
                  end
                  if (position_ff >= PT_FRAME_END) begin
                     position_in     = '0;
                     repeats_left_in = repeats_left_ff - 8'd1;
                  end else begin
                     position_in = position_ff + 7'd1;
                  end
               end
            end
         end
         CMD_LOAD12, CMD_LOAD_HOUSE, CMD_LOAD_444: begin
            pattern_in       = tristate_code(request.command, request.house_code,
                                             request.code_word, request.state_bits);
            doorbell_mode_in = 1'b0;
            repeats_left_in  = cfg.pt_repeat_count;
         end
         CMD_RAW: begin
            pattern_in       = request.raw_pattern;
            doorbell_mode_in = 1'b0;
            repeats_left_in  = cfg.pt_repeat_count;
         end
         CMD_BELL: begin
            // The doorbell code fills only the first two bytes.
            pattern_in[23:16] = request.code_word[7:0];
            pattern_in[15:8]  = {request.state_bits, 4'b0000};
            doorbell_mode_in  = 1'b1;
            repeats_left_in   = cfg.hx_repeat_count;
         end
         default: begin
         end
      endcase

      result.tx_level        = line_level_in;
      result.preload_written = tick_written;
      result.preload_value   = tick_preload;
      result.busy_res        = (repeats_left_in != '0);
   end

   assign status.busy     = (repeats_left_ff != '0);
   assign status.position = position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff       <= '0;
         position_ff      <= '0;
         bit_mask_ff      <= '0;
         repeats_left_ff  <= '0;
         doorbell_mode_ff <= 1'b0;
         line_level_ff    <= 1'b0;
      end else if (accept) begin
         pattern_ff       <= pattern_in;
         position_ff      <= position_in;
         bit_mask_ff      <= bit_mask_in;
         repeats_left_ff  <= repeats_left_in;
         doorbell_mode_ff <= doorbell_mode_in;
         line_level_ff    <= line_level_in;
      end
   end

`ifndef SYNTHESIS
   a_position_in_frame: assert property (@(posedge clock) disable iff (reset)
      status.position <= PT_FRAME_END)
      else $error("frame position ran past the tristate frame end");

   a_doorbell_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && doorbell_mode_ff && request.command == CMD_TICK && status.busy
      && position_ff >= HX_FRAME_END |=> position_ff == '0)
      else $error("doorbell frame did not wrap");

   a_mask_shift: assert property (@(posedge clock) disable iff (reset)
      accept && request.command == CMD_TICK && status.busy && !doorbell_mode_ff
      && position_ff < PT_DATA_END && position_ff[0] |=> bit_mask_ff == ($past(mask_eff) >> 1))
      else $error("bit mask did not advance after a data interval");
`endif

endmodule

// ----- src/ook_tristate_remote_encoder.sv -----
// Top level of the tristate on-off-keying remote encoder: control registers and response register.
// The response is registered: the edge that accepts a request loads it into the response register.
// One request per cycle unless the response stalls; its register frees as soon as it is taken.
// The framer state update is one pass of short logic from the state registers to the response.
// Reset is synchronous and active high: the pattern, position, mask, repeat count, mode and line
// level clear, preloads clear, both repeat counts return to four and no response is pending.
module ook_tristate_remote_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ootre_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ootre_pkg::rsp_type rsp_payload,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_write_data
);
   import ootre_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_payload_ff;
   rsp_type    step_result;
   status_type framer_status;
   logic       req_accept;

   // A request is taken whenever the response register is empty or being drained this cycle.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Register writes are captured at the clock edge; indexes past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PT_SHORT:  cfg_in.pt_short_preload = csr_write_data;
            CSR_PT_LONG:   cfg_in.pt_long_preload  = csr_write_data;
            CSR_HX_SHORT:  cfg_in.hx_short_preload = csr_write_data;
            CSR_HX_LONG:   cfg_in.hx_long_preload  = csr_write_data;
            CSR_PT_REPEAT: cfg_in.pt_repeat_count  = csr_write_data;
            CSR_HX_REPEAT: cfg_in.hx_repeat_count  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // The response stays valid while the downstream side stalls it.
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   ootre_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .request (req_payload),
      .cfg     (cfg_ff),
      .result  (step_result),
      .status  (framer_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pt_short_preload <= '0;
         cfg_ff.pt_long_preload  <= '0;
         cfg_ff.hx_short_preload <= '0;
         cfg_ff.hx_long_preload  <= '0;
         cfg_ff.pt_repeat_count  <= REPEAT_RESET;
         cfg_ff.hx_repeat_count  <= REPEAT_RESET;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= step_result;
      end
   end

`ifndef SYNTHESIS
   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_idle_tick_no_preload: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.command == CMD_TICK && !framer_status.busy
      |=> !rsp_payload.preload_written && rsp_payload.preload_value == '0)
      else $error("idle tick chose a preload");

   a_load_no_preload: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.command != CMD_TICK |=> !rsp_payload.preload_written)
      else $error("load request chose a preload");

   a_raw_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.command == CMD_RAW
      |=> rsp_payload.busy_res == ($past(cfg_ff.pt_repeat_count) != '0))
      else $error("raw load busy flag does not follow the armed repeat count");
`endif

endmodule

// ----- sim/tb_ook_tristate_remote_encoder.sv -----
// Self-checking testbench for the tristate on-off-keying remote encoder.
module tb_ook_tristate_remote_encoder;
   import ootre_pkg::*;

   // Command codes 6 and 7 have no meaning; the block answers them like an idle tick.
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // Each phase runs under its own register setting. A phase ends once this many requests
   // have been sent, idle ticks included.
   localparam int PHASES         = 6;
   localparam int PHASE_REQUESTS = 250;
   localparam int DIRECTED_ROWS  = 25;

   // The longest correct quiet stretch is a register setup plus the longest response stall,
   // so reaching QUIET_LIMIT without any handshake means the block is stuck.
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_type;

   // One line of the directed table. When typed is set, result holds the response that is
   // expected; otherwise the predictor supplies it.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type result;
   } stim_row_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   req_type    req_payload      = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_write_enable = 1'b0;
   logic [2:0] csr_index        = CSR_PT_SHORT;
   logic [7:0] csr_write_data   = 8'h00;

   ook_tristate_remote_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the framer. The 24-bit pattern is kept as one vector with the first
   // transmitted bit (byte 0, msb) in bit 23.
   cfg_type     csr_shadow   = {8'h00, 8'h00, 8'h00, 8'h00, REPEAT_RESET, REPEAT_RESET};
   logic [23:0] frame_bits   = '0;
   logic [6:0]  frame_pos    = '0;
   logic [7:0]  frame_mask   = '0;
   logic [7:0]  repeats_owed = '0;
   logic        bell_mode    = 1'b0;
   logic        line_high    = 1'b0;

   rsp_type         line_forecast[$];
   stim_row_type    directed_rows[DIRECTED_ROWS];
   int              mismatch_count = 0;
   int              sent_requests  = 0;
   int              burst_left     = 0;
   int              quiet_cycles   = 0;
   stall_style_type stall_style    = STALL_NONE;
   int              style_left     = 0;
   int              stall_left     = 0;

   // Advances the shadow framer by one request and returns the response it should give.
   function automatic rsp_type framer_step(input req_type item);
      rsp_type    result;
      logic       set;
      logic       hit;
      logic       wrote;
      logic [7:0] preload;
      int         i;
      int         byte_sel;
      wrote   = 1'b0;
      preload = 8'h00;
      hit     = 1'b0;
      case (item.command)
         CMD_TICK: if (repeats_owed != 8'd0) begin
            wrote = 1'b1;
            // The mask restarts at the start of a frame, and also whenever it has been
            // shifted out, which is how the next byte of the pattern comes into view.
            if (frame_pos == 7'd0 || frame_mask == 8'h00)
               frame_mask = MASK_FIRST;
            if (bell_mode) begin
               // Doorbell framing: a sync pair, 25 data phases, then long gaps.
               if (frame_pos == 7'd0) begin
                  line_high = 1'b0;
                  preload   = csr_shadow.hx_long_preload;
               end else if (frame_pos == 7'd1) begin
                  line_high = 1'b1;
                  preload   = csr_shadow.hx_short_preload;
               end else if (frame_pos <= HX_DATA_END) begin
                  byte_sel = (frame_pos - HX_DATA_BASE) / 16;
                  hit = (frame_bits[23 - 8 * byte_sel -: 8] & frame_mask) != 8'h00;
                  if (!frame_pos[0]) begin
                     line_high = 1'b0;
                     preload   = hit ? csr_shadow.hx_short_preload : csr_shadow.hx_long_preload;
                  end else begin
                     line_high  = 1'b1;
                     preload    = hit ? csr_shadow.hx_long_preload : csr_shadow.hx_short_preload;
                     frame_mask = frame_mask >> 1;
                  end
               end else begin
                  line_high = 1'b0;
                  preload   = csr_shadow.hx_long_preload;
               end
            end else begin
               // Tristate framing: 48 data intervals, a sync pulse, then short gaps.
               if (frame_pos < PT_DATA_END) begin
                  byte_sel = frame_pos / 16;
                  hit = (frame_bits[23 - 8 * byte_sel -: 8] & frame_mask) != 8'h00;
                  if (!frame_pos[0]) begin
                     line_high = 1'b1;
                     preload   = hit ? csr_shadow.pt_long_preload : csr_shadow.pt_short_preload;
                  end else begin
                     line_high  = 1'b0;
                     preload    = hit ? csr_shadow.pt_short_preload : csr_shadow.pt_long_preload;
                     frame_mask = frame_mask >> 1;
                  end
               end else begin
                  if (frame_pos == PT_DATA_END)
                     line_high = 1'b1;
                  else if (frame_pos == PT_SYNC_LOW)
                     line_high = 1'b0;
                  preload = csr_shadow.pt_short_preload;
               end
            end
            // A position beyond the end of the current mode's frame (left over from the
            // other mode) still wraps here and uses up one repetition.
            if (frame_pos >= (bell_mode ? HX_FRAME_END : PT_FRAME_END)) begin
               frame_pos    = 7'd0;
               repeats_owed = repeats_owed - 8'd1;
            end else begin
               frame_pos = frame_pos + 7'd1;
            end
         end
         CMD_LOAD12, CMD_LOAD_HOUSE, CMD_LOAD_444: begin
            // Each of the 12 tristate code bits becomes a pair: set gives 00, clear gives 01.
            for (i = 0; i < 12; i++) begin
               case (item.command)
                  CMD_LOAD12: set = item.code_word[i];
                  CMD_LOAD_HOUSE:
                     if (i < 5)
                        set = item.house_code[i];
                     else if (i < 10)
                        set = item.code_word == i - 5;
                     else
                        set = item.state_bits[i - 10];
                  default:
                     if (i < 4)
                        set = item.house_code[i];
                     else if (i < 8)
                        set = item.code_word[i - 4];
                     else
                        set = item.state_bits[i - 8];
               endcase
               frame_bits[23 - 2 * i] = 1'b0;
               frame_bits[22 - 2 * i] = ~set;
            end
            bell_mode    = 1'b0;
            repeats_owed = csr_shadow.pt_repeat_count;
         end
         CMD_RAW: begin
            frame_bits   = item.raw_pattern;
            bell_mode    = 1'b0;
            repeats_owed = csr_shadow.pt_repeat_count;
         end
         CMD_BELL: begin
            // Only the first two pattern bytes are replaced; the third one is kept.
            frame_bits[23:16] = item.code_word[7:0];
            frame_bits[15:8]  = {item.state_bits, 4'h0};
            bell_mode         = 1'b1;
            repeats_owed      = csr_shadow.hx_repeat_count;
         end
         default: ;
      endcase
      result.tx_level        = line_high;
      result.preload_written = wrote;
      result.preload_value   = preload;
      result.busy_res        = repeats_owed != 8'd0;
      return result;
   endfunction

   // Random request with every field filled with noise, then the command forced.
   function automatic req_type random_request(input logic [2:0] command);
      req_type     item;
      logic [63:0] noise;
      noise        = {$urandom, $urandom};
      item         = noise[$bits(req_type)-1:0];
      item.command = command;
      // Channel numbers mostly land near the valid range of 0 to 4 so that each channel
      // pair gets exercised; the rest use the whole 12-bit field.
      if (command == CMD_LOAD_HOUSE && $urandom_range(0, 3) != 0)
         item.code_word = 12'($urandom_range(0, 6));
      return item;
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // Presents one request and holds it until the block takes it. The expectation is worked
   // out at the edge where the request is accepted. The sender runs in bursts with random
   // gaps; a gap of zero keeps valid high into the next request.
   task automatic send_request(input req_type item, input logic typed, input rsp_type typed_result);
      rsp_type want;
      int      gap;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      want = framer_step(item);
      line_forecast.push_back(typed ? typed_result : want);
      sent_requests++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
   endtask

   task automatic send_ticks(input int count);
      int n;
      for (n = 0; n < count; n++)
         send_request(random_request(CMD_TICK), 1'b0, '0);
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Response side: every accepted response is matched against the oldest expectation.
   // The stall pattern switches between no stalls, short stalls and long stalls, each style
   // lasting a random number of cycles, so stalls land on every phase of a frame.
   always @(posedge clock) begin : response_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_forecast.size() == 0) begin
            $display("%0t: response with none expected: expected none, got %0h",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = line_forecast.pop_front();
            check_field("tx_level", want.tx_level, rsp_payload.tx_level);
            check_field("preload_written", want.preload_written, rsp_payload.preload_written);
            check_field("preload_value", want.preload_value, rsp_payload.preload_value);
            check_field("busy_res", want.busy_res, rsp_payload.busy_res);
         end
      end
      if (style_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 2));
         style_left  = $urandom_range(32, 256);
      end else begin
         style_left--;
      end
      if (stall_left != 0) begin
         stall_left--;
      end else if (rsp_stall || stall_style == STALL_NONE) begin
         rsp_stall  <= 1'b0;
         stall_left = (stall_style == STALL_HEAVY) ? $urandom_range(0, 2) : $urandom_range(0, 8);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left = (stall_style == STALL_HEAVY) ? $urandom_range(3, 11) : $urandom_range(0, 2);
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      cfg_type     setting;
      logic [63:0] noise;
      int          phase;
      int          row;
      int          pick;

      // The first rows, the unused commands among them, run right after reset with short preload
      // 00, long preload FF and a tristate repeat count of two, so their answers can be read off
      // directly. The rest walk the special cases: every load layout, channel numbers out of
      // range, a doorbell load that keeps the third byte, and switches of mode mid-frame.
      directed_rows = '{
         // idle tick and unused commands do nothing
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_SPARE_LO,   5'h1F, 12'hFFF, 4'hF, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_SPARE_HI,   5'h00, 12'h000, 4'h0, 24'h000000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
         // all code bits set: the pattern is all zero
         {CMD_LOAD12,     5'h00, 12'hFFF, 4'h0, 24'h000000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1},
         {CMD_TICK,       5'h1F, 12'hFFF, 4'hF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b1},
         // raw load of all ones; the position is not reset by the load
         {CMD_RAW,        5'h00, 12'h000, 4'h0, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},
         {CMD_LOAD12,     5'h00, 12'h000, 4'h0, 24'h000000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         // house code, highest valid channel, two data bits
         {CMD_LOAD_HOUSE, 5'h1F, 12'h004, 4'h3, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         // channel numbers above four select no channel pair
         {CMD_LOAD_HOUSE, 5'h00, 12'h005, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_LOAD_HOUSE, 5'h15, 12'hFFF, 4'hC, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_LOAD_444,   5'h1F, 12'hFFF, 4'hF, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_RAW,        5'h00, 12'h000, 4'h0, 24'hA5C3F0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         // doorbell load mid-frame keeps the third byte and the position
         {CMD_BELL,       5'h00, 12'h0AB, 4'hF, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_BELL,       5'h1F, 12'hFFF, 4'h0, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         {CMD_TICK,       5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         // back to tristate mode with every code bit clear
         {CMD_LOAD_444,   5'h00, 12'h000, 4'h0, 24'h000000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // Registers change only with nothing in flight. Every request gives exactly one
         // response, so an empty forecast means the block is idle.
         req_valid <= 1'b0;
         while (line_forecast.size() != 0)
            @(negedge clock);
         @(posedge clock);

         // Phases 0 and 2 put the tristate preloads at their extremes, phase 2 turns
         // tristate repetitions off and phase 3 sets the largest tristate count with
         // doorbell repetitions off. Others use random preloads and short repeat counts.
         noise                   = {$urandom, $urandom};
         setting                 = noise[$bits(cfg_type)-1:0];
         setting.pt_repeat_count = 8'($urandom_range(1, 4));
         setting.hx_repeat_count = 8'($urandom_range(1, 4));
         case (phase)
            0: setting = {8'h00, 8'hFF, 8'h5A, 8'hA5, 8'd2, 8'd1};
            1: begin
               setting.pt_repeat_count = 8'd1;
               setting.hx_repeat_count = 8'd3;
            end
            2: setting = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'd0, 8'd2};
            3: begin
               setting.pt_repeat_count = 8'd255;
               setting.hx_repeat_count = 8'd0;
            end
            default: ;
         endcase
         write_csr(CSR_PT_SHORT, setting.pt_short_preload);
         write_csr(CSR_PT_LONG, setting.pt_long_preload);
         write_csr(CSR_HX_SHORT, setting.hx_short_preload);
         write_csr(CSR_HX_LONG, setting.hx_long_preload);
         write_csr(CSR_PT_REPEAT, setting.pt_repeat_count);
         write_csr(CSR_HX_REPEAT, setting.hx_repeat_count);
         csr_write_enable <= 1'b0;
         csr_shadow = setting;

         sent_requests = 0;
         if (phase == 0)
            for (row = 0; row < DIRECTED_ROWS; row++)
               send_request(directed_rows[row].item, directed_rows[row].typed,
                            directed_rows[row].result);

         // Most of the traffic is a load followed by a run of ticks, long enough at times to
         // finish whole frames and use up repetitions. Some sequences load tristate, run past
         // the end of a doorbell frame and then switch to doorbell mode. The rest is noise
         // with any command, the unused ones included.
         while (sent_requests < PHASE_REQUESTS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               send_request(random_request(3'(CMD_LOAD12 + $urandom_range(0, 4))), 1'b0, '0);
               send_ticks($urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(25, 250));
            end else if (pick == 7) begin
               send_request(random_request(3'(CMD_LOAD12 + $urandom_range(0, 3))), 1'b0, '0);
               send_ticks($urandom_range(33, 80));
               send_request(random_request(CMD_BELL), 1'b0, '0);
               send_ticks($urandom_range(1, 40));
            end else begin
               repeat ($urandom_range(1, 8))
                  send_request(random_request(3'($urandom_range(0, 7))), 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (line_forecast.size() != 0)
         @(negedge clock);
      // Wait SETTLE_CYCLES more so that a stray extra response would still be caught.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && line_forecast.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
